@@ src/ccp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared types and constants for the coefficient compress / pack block.
// ----------------------------------------------------------------------------
package ccp_pkg;

  // Payload and configuration port widths
  localparam int VALUE_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_COEFF = 2'd1;

  // Direction codes
  localparam logic DIR_COMPRESS   = 1'b0;
  localparam logic DIR_DECOMPRESS = 1'b1;

  // Compressed width limits and reset value
  localparam int         D_MAX   = 5;
  localparam logic [2:0] D_LO    = 3'd3;
  localparam logic [2:0] D_HI    = 3'd5;
  localparam logic [2:0] D_RESET = 3'd4;

  // Bit accumulator
  localparam int BUF_W  = 12;
  localparam int CNT_W  = 4;
  localparam int BYTE_W = 8;

  // Up to three results per request, held in a small drain queue
  localparam int MAX_RES = 3;
  localparam int LEFT_W  = 2;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [BUF_W-1:0]   buffer_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [LEFT_W-1:0]  left_t;

endpackage

@@ src/coefficient_compress_pack_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coefficient_compress_pack_top
// Coefficient compress / decompress with LSB-first byte packing.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes direction
//   (index 0) and bits_per_coeff (index 1); cfg_ready is always high. Every
//   register write drops any partly packed bits. Write only while idle.
//   in channel takes one coefficient (compress) or one packed byte
//   (decompress) per request. out channel returns packed bytes or rebuilt
//   coefficients; run_last flags the final result of a request.
// Results of a request appear in the cycle after it is accepted.
// Results: each request causes N results (0 or 1 when compressing, up to 3
//   when decompressing with a width of 3). The result queue drains one
//   result per cycle while out_ready is high, and the next request enters in
//   the cycle its last result is taken.
// Reset: direction = compress, width = 4, accumulator empty, queue empty.
// Stall: while out_ready is low the queue holds and in_ready stays low once
//   the last result of the current request is waiting.
// ----------------------------------------------------------------------------
module coefficient_compress_pack_top #(
  parameter int MODULUS     = 3329,
  parameter int COEFF_WIDTH = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ccp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccp_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ccp_pkg::VALUE_W-1:0]  in_value,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ccp_pkg::VALUE_W-1:0]  out_value,
  output logic                         run_last
);
  import ccp_pkg::*;

  // Division by MODULUS as an exact multiply by a rounded-up reciprocal
  localparam int NUM_W    = COEFF_WIDTH + 6;
  localparam int MOD_BITS = $clog2(MODULUS);
  localparam int SHIFT    = NUM_W + MOD_BITS;
  localparam int RECIP_W  = NUM_W + 2;
  localparam int PROD_W   = NUM_W + RECIP_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + longint'(MODULUS) - 1) / longint'(MODULUS);
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_FULL);
  localparam logic [NUM_W-1:0]   HALF_MOD = NUM_W'(MODULUS / 2);

  // Reconstruction product width
  localparam int MODW  = $clog2(MODULUS + 1);
  localparam int SUM_W = D_MAX + MODW + 1;
  localparam logic [SUM_W-1:0] MOD_S = SUM_W'(MODULUS);

  localparam logic [D_MAX-1:0] ALL_ONES = '1;

  // Registers
  logic                  direction;
  logic [2:0]            bits_per_coeff;
  buffer_t               bit_buffer;
  count_t                bit_count;
  value_t                res_q [MAX_RES];
  left_t                 res_left;

  // Next values
  buffer_t               bit_buffer_next;
  count_t                bit_count_next;
  value_t                res_next [MAX_RES];
  left_t                 n_res;

  logic                  accept;
  logic                  take;
  logic [2:0]            d_eff;
  logic [D_MAX-1:0]      mask;

  // Compress datapath
  logic [COEFF_WIDTH-1:0] coef;
  logic [NUM_W-1:0]       num;
  logic [PROD_W-1:0]      prod;
  logic [D_MAX-1:0]       t_val;
  logic [CNT_W:0]         c_cnt;
  buffer_t                c_merged;

  assign accept    = in_valid && in_ready;
  assign take      = out_valid && out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = (res_left != '0);
  assign run_last  = (res_left == left_t'(1));
  assign out_value = res_q[0];
  assign in_ready  = (res_left == '0) || ((res_left == left_t'(1)) && out_ready);

  // Effective width, clamped to 3..5
  always_comb begin
    if (bits_per_coeff < D_LO) begin
      d_eff = D_LO;
    end else if (bits_per_coeff > D_HI) begin
      d_eff = D_HI;
    end else begin
      d_eff = bits_per_coeff;
    end
    mask = ~(ALL_ONES << d_eff);
  end

  // Compress: t = ((c << d) + q/2) / q, cut to d bits
  assign coef     = in_value[COEFF_WIDTH-1:0];
  assign num      = (NUM_W'(coef) << d_eff) + HALF_MOD;
  assign prod     = PROD_W'(num) * PROD_W'(RECIP);
  assign t_val    = prod[SHIFT +: D_MAX] & mask;
  assign c_cnt    = {1'b0, bit_count} + (CNT_W+1)'(d_eff);
  assign c_merged = bit_buffer | (BUF_W'(t_val) << bit_count);

  // Next accumulator state and result set for the offered request
  always_comb begin
    buffer_t          d_buf;
    logic [CNT_W:0]   d_cnt;
    logic [D_MAX-1:0] v;
    logic [SUM_W-1:0] rsum;
    logic [SUM_W-1:0] rval;
    d_buf = '0;
    d_cnt = '0;
    v     = '0;
    rsum  = '0;
    rval  = '0;
    for (int k = 0; k < MAX_RES; k++) begin
      res_next[k] = '0;
    end
    n_res = '0;
    if (direction == DIR_COMPRESS) begin
      if (c_cnt >= (CNT_W+1)'(BYTE_W)) begin
        res_next[0]     = VALUE_W'(c_merged[BYTE_W-1:0]);
        bit_buffer_next = c_merged >> BYTE_W;
        bit_count_next  = CNT_W'(c_cnt - (CNT_W+1)'(BYTE_W));
        n_res           = left_t'(1);
      end else begin
        bit_buffer_next = c_merged;
        bit_count_next  = c_cnt[CNT_W-1:0];
      end
    end else begin
      // Decompress: append the byte, then pull d-bit fields LSB first
      d_buf = bit_buffer | (BUF_W'(in_value[BYTE_W-1:0]) << bit_count);
      d_cnt = {1'b0, bit_count} + (CNT_W+1)'(BYTE_W);
      for (int k = 0; k < MAX_RES; k++) begin
        if (d_cnt >= (CNT_W+1)'(d_eff)) begin
          v           = d_buf[D_MAX-1:0] & mask;
          rsum        = SUM_W'(v) * MOD_S + (SUM_W'(1) << (d_eff - 3'd1));
          rval        = rsum >> d_eff;
          res_next[k] = VALUE_W'(rval);
          d_buf       = d_buf >> d_eff;
          d_cnt       = d_cnt - (CNT_W+1)'(d_eff);
          n_res       = n_res + left_t'(1);
        end
      end
      bit_buffer_next = d_buf;
      bit_count_next  = d_cnt[CNT_W-1:0];
    end
  end

  // Control state: configuration, accumulator, queue occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      direction      <= DIR_COMPRESS;
      bits_per_coeff <= D_RESET;
      bit_buffer     <= '0;
      bit_count      <= '0;
      res_left       <= '0;
    end else begin
      if (accept) begin
        res_left <= n_res;
      end else if (take) begin
        res_left <= res_left - left_t'(1);
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DIRECTION: begin
            direction  <= cfg_data[0];
            bit_buffer <= '0;
            bit_count  <= '0;
          end
          REG_BITS_PER_COEFF: begin
            bits_per_coeff <= cfg_data;
            bit_buffer     <= '0;
            bit_count      <= '0;
          end
          default: begin
          end
        endcase
      end else if (accept) begin
        bit_buffer <= bit_buffer_next;
        bit_count  <= bit_count_next;
      end
    end
  end

  // Result queue: load on accept, shift down on each taken result
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MAX_RES; k++) begin
        res_q[k] <= res_next[k];
      end
    end else if (take) begin
      for (int k = 0; k < MAX_RES - 1; k++) begin
        res_q[k] <= res_q[k+1];
      end
    end
  end

  // Assertions
  a_comp_one_result: assert property (@(posedge clk) disable iff (rst)
    accept && (direction == DIR_COMPRESS) |=> (res_left <= left_t'(1)))
    else $error("compress request produced more than one result");

  a_comp_count: assert property (@(posedge clk) disable iff (rst)
    (direction == DIR_COMPRESS) |-> (bit_count < count_t'(BYTE_W)))
    else $error("compress accumulator holds a full byte");

  a_decomp_count: assert property (@(posedge clk) disable iff (rst)
    (direction == DIR_DECOMPRESS) |-> (bit_count < count_t'(d_eff)))
    else $error("decompress accumulator holds a full field");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> (res_left == $past(res_left)))
    else $error("result queue moved while stalled");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    take && run_last && !accept |=> !out_valid)
    else $error("results left after the last one was taken");

endmodule
